### sv/multi_stream_dma_controller_defines.svh
// Assertion macros used by the top level of the multi-stream DMA controller RTL.
`ifndef MULTI_STREAM_DMA_CONTROLLER_DEFINES_SVH
`define MULTI_STREAM_DMA_CONTROLLER_DEFINES_SVH
`ifndef ASSERT_OFF
`define MSDMA_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("msdma property violated");
`define MSDMA_ASSERT_NEVER(label, clk, rstn, cond) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("msdma forbidden condition seen");
`else
`define MSDMA_ASSERT(label, clk, rstn, prop)
`define MSDMA_ASSERT_NEVER(label, clk, rstn, cond)
`endif
`endif

### sv/msdma_pkg.sv
// Types, constants and helper functions of the multi-stream DMA controller.
`timescale 1ns / 1ps
package msdma_pkg;

  localparam int unsigned MapWords        = 52;
  localparam int unsigned FirstStreamWord = 4;
  localparam int unsigned WordsPerStream  = 6;
  localparam int unsigned MaxStreams      = 8;

  localparam logic [5:0] FlagGroup   = 6'b111101;
  localparam logic [5:0] EnableGroup = 6'b111110;
  localparam logic [5:0] FlagHalf    = 6'h10;
  localparam logic [5:0] FlagDone    = 6'h20;

  // Operation codes.
  localparam logic [1:0] OpWrite   = 2'd0;
  localparam logic [1:0] OpRead    = 2'd1;
  localparam logic [1:0] OpRequest = 2'd2;
  localparam logic [1:0] OpTick    = 2'd3;

  // Word codes within a stream's register group.
  localparam logic [2:0] WordCtrl   = 3'd0;
  localparam logic [2:0] WordCount  = 3'd1;
  localparam logic [2:0] WordPeriph = 3'd2;
  localparam logic [2:0] WordMem0   = 3'd3;
  localparam logic [2:0] WordMem1   = 3'd4;
  localparam logic [2:0] WordFifo   = 3'd5;

  localparam logic KindReply = 1'b0;
  localparam logic KindXfer  = 1'b1;

  // Classified input beat.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [5:0]  reg_index;
    logic        lane_ok;
    logic [31:0] lane_mask;
    logic [4:0]  lane_shift;
    logic [31:0] write_data;
    logic        request_dir;
    logic [31:0] request_address;
  } item_t;

  typedef struct packed {
    logic       stream_word;
    logic [2:0] stream;
    logic [2:0] word;
  } reg_loc_t;

  typedef struct packed {
    logic [2:0]  stream;
    logic [31:0] source;
    logic [31:0] dest;
    logic [2:0]  source_bytes;
    logic [2:0]  dest_bytes;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] read_data;
    cmd_t        cmd;
    logic [7:0]  irq_lines;
    logic        last;
  } result_t;

  typedef struct packed {
    logic busy;
    logic emitting;
  } exec_status_t;

  // Map a word index onto a stream and a word within its group.
  function automatic reg_loc_t reg_locate(logic [5:0] idx);
    reg_loc_t   loc;
    logic [5:0] rel;
    loc = '0;
    rel = idx - 6'(FirstStreamWord);
    if (idx >= 6'(FirstStreamWord) && idx < 6'(MapWords)) begin
      loc.stream_word = 1'b1;
      for (int s = 0; s < int'(MaxStreams); s++) begin
        if (rel >= 6'(s * int'(WordsPerStream))) begin
          loc.stream = 3'(s);
          loc.word   = 3'(rel - 6'(s * int'(WordsPerStream)));
        end
      end
    end
    return loc;
  endfunction

  // Size code to bytes; the reserved code gives zero.
  function automatic logic [2:0] size_bytes(logic [1:0] code);
    logic [2:0] b;
    case (code)
      2'd0:    b = 3'd1;
      2'd1:    b = 3'd2;
      2'd2:    b = 3'd4;
      default: b = 3'd0;
    endcase
    return b;
  endfunction

  // Bit position of a stream's flag group within its status word.
  function automatic logic [4:0] group_shift(logic [2:0] s);
    logic [4:0] sh;
    sh = 5'd0;
    if (s[1]) sh = sh + 5'd16;
    if (s[0]) sh = sh + 5'd6;
    return sh;
  endfunction

endpackage

### sv/msdma_front.sv
// Front end: accepts beats, classifies the access lane and queues them.
`timescale 1ns / 1ps
module msdma_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           opcode_i,
  input  logic [5:0]           reg_index_i,
  input  logic [1:0]           byte_offset_i,
  input  logic [2:0]           access_bytes_i,
  input  logic [31:0]          write_data_i,
  input  logic                 request_dir_i,
  input  logic [31:0]          request_address_i,
  input  logic                 pop_i,
  output logic                 item_valid_o,
  output msdma_pkg::item_t     item_o
);

  msdma_pkg::item_t item_in;
  msdma_pkg::item_t entries_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       count_q;
  logic             push;
  logic             pop;

  // Decode the lane of the access once, at the door.
  always_comb begin
    item_in                 = '0;
    item_in.opcode          = opcode_i;
    item_in.reg_index       = reg_index_i;
    item_in.write_data      = write_data_i;
    item_in.request_dir     = request_dir_i;
    item_in.request_address = request_address_i;
    if (access_bytes_i == 3'd4) begin
      item_in.lane_ok    = 1'b1;
      item_in.lane_mask  = 32'hFFFF_FFFF;
      item_in.lane_shift = 5'd0;
    end else if (access_bytes_i == 3'd2) begin
      item_in.lane_ok    = 1'b1;
      item_in.lane_mask  = 32'h0000_FFFF;
      item_in.lane_shift = {byte_offset_i, 3'b000};
    end
  end

  assign in_stall_o   = (count_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign item_valid_o = (count_q != 2'd0);
  assign pop          = pop_i && item_valid_o;
  assign item_o       = entries_q[rd_ptr_q];

  // Two-entry queue between the bus side and the sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

### sv/msdma_exec.sv
// Back end: register file, request bookkeeping and the stream service walk.
`timescale 1ns / 1ps
module msdma_exec #(
  parameter int unsigned STREAMS     = 8,
  parameter int unsigned QUEUE_SLOTS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    item_valid_i,
  input  msdma_pkg::item_t        item_i,
  output logic                    pop_o,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  output msdma_pkg::result_t      res_o,
  output msdma_pkg::exec_status_t status_o
);

  localparam int unsigned SW = (STREAMS > 1) ? $clog2(STREAMS) : 1;
  localparam int unsigned CW = $clog2(STREAMS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_TICK = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]       state_q;
  msdma_pkg::item_t item_q;
  logic [SW-1:0]    scnt_q;
  logic [CW-1:0]    ncmd_q;
  logic [CW-1:0]    ecnt_q;
  logic [31:0]      reply_q;
  msdma_pkg::cmd_t  cmd_q [STREAMS];

  logic [31:0] ctrl_q [STREAMS];
  logic [31:0] cnt_q  [STREAMS];
  logic [31:0] pa_q   [STREAMS];
  logic [31:0] m0_q   [STREAMS];
  logic [31:0] m1_q   [STREAMS];
  logic [31:0] fifo_q [STREAMS];
  logic [15:0] svc_q  [STREAMS];
  logic [31:0] svm_q  [STREAMS];
  logic [31:0] svp_q  [STREAMS];
  logic [7:0]  pend_q [STREAMS];
  logic [31:0] flag_q [2];
  logic [31:0]            qaddr_q [2][QUEUE_SLOTS];
  logic [QUEUE_SLOTS-1:0] qval_q  [2];

  msdma_pkg::reg_loc_t loc;
  logic          reg_ok;
  logic [SW-1:0] sel_s;
  logic [31:0]   cr;
  logic [31:0]   rv;
  logic [31:0]   lane_m;
  logic [31:0]   merged;
  logic          is_clear;
  logic          en_rise;
  logic          en_fall;
  logic [1:0]    qdir;
  logic [QUEUE_SLOTS-1:0] take_oh;
  logic [STREAMS-1:0]     rq_match;
  logic                   rq_hit;
  logic                   rq_dup;
  logic [QUEUE_SLOTS-1:0] free_oh;
  logic          found_take;
  logic          found_free;
  logic [2:0]    psz;
  logic [2:0]    msz;
  logic [2:0]    pinc;
  logic [2:0]    minc;
  logic          xfer_go;
  msdma_pkg::cmd_t cmd_new;
  logic [31:0]   ncnt;
  logic [31:0]   npa;
  logic [31:0]   nm0;
  logic [31:0]   pback;
  logic [31:0]   mback;
  logic          flag_hi;
  logic [4:0]    flag_sh;
  logic [7:0]    irq;
  logic          emit_last;

  function automatic logic [7:0] sat_inc(logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  // Count times a step of 0, 1, 2 or 4 bytes.
  function automatic logic [31:0] scaled(logic [15:0] n, logic [2:0] step);
    logic [31:0] r;
    case (step)
      3'd1:    r = {16'd0, n};
      3'd2:    r = {15'd0, n, 1'b0};
      3'd4:    r = {14'd0, n, 2'b00};
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // One stream is selected at a time: by the register index or by the walk.
  assign loc    = msdma_pkg::reg_locate(item_q.reg_index);
  assign reg_ok = loc.stream_word && ({1'b0, loc.stream} < 4'(STREAMS));
  assign sel_s  = (state_q == ST_TICK) ? scnt_q : loc.stream[SW-1:0];
  assign cr     = ctrl_q[sel_s];

  // Register read value and the merged write word.
  always_comb begin
    rv = 32'd0;
    if (item_q.reg_index < 6'd2) begin
      rv = flag_q[item_q.reg_index[0]];
    end else if (reg_ok) begin
      case (loc.word)
        msdma_pkg::WordCtrl:   rv = ctrl_q[sel_s];
        msdma_pkg::WordCount:  rv = cnt_q[sel_s];
        msdma_pkg::WordPeriph: rv = pa_q[sel_s];
        msdma_pkg::WordMem0:   rv = m0_q[sel_s];
        msdma_pkg::WordMem1:   rv = m1_q[sel_s];
        default:               rv = fifo_q[sel_s];
      endcase
    end
    is_clear = (item_q.reg_index == 6'd2) || (item_q.reg_index == 6'd3);
    lane_m   = item_q.lane_mask << item_q.lane_shift;
    merged   = ((is_clear ? 32'd0 : rv) & ~lane_m)
             | ((item_q.write_data << item_q.lane_shift) & lane_m);
  end

  // Enable edge on a control write and the queued request it claims.
  always_comb begin
    en_rise    = !cr[0] && merged[0];
    en_fall    = cr[0] && !merged[0];
    qdir       = merged[7:6];
    take_oh    = '0;
    found_take = 1'b0;
    for (int q = 0; q < int'(QUEUE_SLOTS); q++) begin
      if (!found_take && qval_q[qdir[0]][q] && qaddr_q[qdir[0]][q] == pa_q[sel_s]) begin
        take_oh[q] = 1'b1;
        found_take = 1'b1;
      end
    end
  end

  // Peripheral request: stream matches, duplicate check and free slot.
  always_comb begin
    for (int s = 0; s < int'(STREAMS); s++) begin
      rq_match[s] = (pa_q[s] == item_q.request_address)
                 && (ctrl_q[s][7:6] == {1'b0, item_q.request_dir})
                 && ctrl_q[s][0] && (cnt_q[s] != 32'd0);
    end
    rq_hit     = |rq_match;
    rq_dup     = 1'b0;
    free_oh    = '0;
    found_free = 1'b0;
    for (int q = 0; q < int'(QUEUE_SLOTS); q++) begin
      if (qval_q[item_q.request_dir][q]) begin
        if (qaddr_q[item_q.request_dir][q] == item_q.request_address) rq_dup = 1'b1;
      end else if (!found_free) begin
        free_oh[q] = 1'b1;
        found_free = 1'b1;
      end
    end
  end

  // Transfer step of the stream under the walk.
  always_comb begin
    psz     = msdma_pkg::size_bytes(cr[12:11]);
    msz     = msdma_pkg::size_bytes(cr[14:13]);
    pinc    = cr[9] ? (cr[15] ? 3'd4 : psz) : 3'd0;
    minc    = cr[10] ? msz : 3'd0;
    xfer_go = cr[0] && !cr[7];
    cmd_new.stream       = 3'(sel_s);
    cmd_new.source       = cr[6] ? m0_q[sel_s] : pa_q[sel_s];
    cmd_new.dest         = cr[6] ? pa_q[sel_s] : m0_q[sel_s];
    cmd_new.source_bytes = cr[6] ? msz : psz;
    cmd_new.dest_bytes   = cr[6] ? psz : msz;
    ncnt    = cnt_q[sel_s] - 32'd1;
    npa     = pa_q[sel_s] + 32'(pinc);
    nm0     = m0_q[sel_s] + 32'(minc);
    pback   = npa - scaled(svc_q[sel_s], pinc);
    mback   = nm0 - scaled(svc_q[sel_s], minc);
    flag_hi = (4'(sel_s) > 4'd3);
    flag_sh = msdma_pkg::group_shift(3'(sel_s));
  end

  // Interrupt levels from flags and enables.
  always_comb begin
    logic [5:0] sr;
    logic [6:0] en;
    irq = 8'd0;
    for (int s = 0; s < int'(STREAMS); s++) begin
      sr = 6'(flag_q[(s > 3) ? 1 : 0] >> msdma_pkg::group_shift(3'(s)))
         & msdma_pkg::FlagGroup;
      en = {ctrl_q[s][5:1], 1'b0, fifo_q[s][7]};
      irq[s] = |({1'b0, sr} & en);
    end
  end

  assign pop_o       = (state_q == ST_IDLE) && item_valid_i;
  assign res_valid_o = (state_q == ST_EMIT);
  assign emit_last   = (ecnt_q == ncmd_q);
  assign status_o.busy     = (state_q != ST_IDLE);
  assign status_o.emitting = (state_q == ST_EMIT);

  // Result beat: queued commands first, then the closing reply.
  always_comb begin
    res_o           = '0;
    res_o.irq_lines = irq;
    res_o.last      = emit_last;
    if (emit_last) begin
      res_o.kind      = msdma_pkg::KindReply;
      res_o.read_data = reply_q;
    end else begin
      res_o.kind = msdma_pkg::KindXfer;
      res_o.cmd  = cmd_q[ecnt_q[SW-1:0]];
    end
  end

  // Sequencer and all architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      scnt_q  <= '0;
      ncmd_q  <= '0;
      ecnt_q  <= '0;
      reply_q <= '0;
      flag_q[0] <= '0;
      flag_q[1] <= '0;
      qval_q[0] <= '0;
      qval_q[1] <= '0;
      for (int q = 0; q < int'(QUEUE_SLOTS); q++) begin
        qaddr_q[0][q] <= '0;
        qaddr_q[1][q] <= '0;
      end
      for (int s = 0; s < int'(STREAMS); s++) begin
        ctrl_q[s] <= '0;
        cnt_q[s]  <= '0;
        pa_q[s]   <= '0;
        m0_q[s]   <= '0;
        m1_q[s]   <= '0;
        fifo_q[s] <= '0;
        svc_q[s]  <= '0;
        svm_q[s]  <= '0;
        svp_q[s]  <= '0;
        pend_q[s] <= '0;
      end
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (item_valid_i) begin
            state_q <= (item_i.opcode == msdma_pkg::OpTick) ? ST_TICK : ST_RUN;
            scnt_q  <= SW'(STREAMS - 1);
            ncmd_q  <= '0;
            ecnt_q  <= '0;
            reply_q <= '0;
          end
        end
        ST_RUN: begin
          state_q <= ST_EMIT;
          case (item_q.opcode)
            msdma_pkg::OpWrite: begin
              if (item_q.lane_ok) begin
                if (is_clear) begin
                  flag_q[item_q.reg_index[0]] <= flag_q[item_q.reg_index[0]] & ~merged;
                end else if (reg_ok) begin
                  case (loc.word)
                    msdma_pkg::WordCtrl: begin
                      ctrl_q[sel_s] <= merged;
                      if (en_rise && !qdir[1] && (|take_oh)) begin
                        qval_q[qdir[0]] <= qval_q[qdir[0]] & ~take_oh;
                        pend_q[sel_s]   <= sat_inc(pend_q[sel_s]);
                      end
                      if (en_fall) begin
                        m0_q[sel_s] <= svm_q[sel_s];
                        pa_q[sel_s] <= svp_q[sel_s];
                      end
                    end
                    msdma_pkg::WordCount: begin
                      svc_q[sel_s] <= merged[15:0];
                      cnt_q[sel_s] <= merged;
                    end
                    msdma_pkg::WordPeriph: begin
                      svp_q[sel_s] <= merged;
                      pa_q[sel_s]  <= merged;
                    end
                    msdma_pkg::WordMem0: begin
                      svm_q[sel_s] <= merged;
                      m0_q[sel_s]  <= merged;
                    end
                    msdma_pkg::WordMem1: m1_q[sel_s] <= merged;
                    default:             fifo_q[sel_s] <= merged;
                  endcase
                end
              end
            end
            msdma_pkg::OpRead: begin
              reply_q <= item_q.lane_ok ? ((rv >> item_q.lane_shift) & item_q.lane_mask)
                                        : 32'd0;
            end
            msdma_pkg::OpRequest: begin
              for (int s = 0; s < int'(STREAMS); s++) begin
                if (rq_match[s]) pend_q[s] <= sat_inc(pend_q[s]);
              end
              if (!rq_hit && !rq_dup) begin
                qval_q[item_q.request_dir] <= qval_q[item_q.request_dir] | free_oh;
                for (int q = 0; q < int'(QUEUE_SLOTS); q++) begin
                  if (free_oh[q]) qaddr_q[item_q.request_dir][q] <= item_q.request_address;
                end
              end
            end
            default: ;
          endcase
        end
        ST_TICK: begin
          if (pend_q[sel_s] != 8'd0) begin
            pend_q[sel_s] <= pend_q[sel_s] - 8'd1;
            if (xfer_go) begin
              cmd_q[ncmd_q[SW-1:0]] <= cmd_new;
              ncmd_q <= ncmd_q + CW'(1);
              if (ncnt == 32'd0) begin
                flag_q[flag_hi] <= flag_q[flag_hi] | (32'(msdma_pkg::FlagDone) << flag_sh);
                if (cr[8]) begin
                  cnt_q[sel_s] <= 32'(svc_q[sel_s]);
                  pa_q[sel_s]  <= pback;
                  m0_q[sel_s]  <= mback;
                end else begin
                  cnt_q[sel_s]  <= ncnt;
                  pa_q[sel_s]   <= npa;
                  m0_q[sel_s]   <= nm0;
                  ctrl_q[sel_s] <= cr & ~32'd1;
                end
              end else begin
                cnt_q[sel_s] <= ncnt;
                pa_q[sel_s]  <= npa;
                m0_q[sel_s]  <= nm0;
                if (ncnt == 32'(svc_q[sel_s] >> 1)) begin
                  flag_q[flag_hi] <= flag_q[flag_hi]
                                   | (32'(msdma_pkg::FlagHalf) << flag_sh);
                end
              end
            end
          end
          if (scnt_q == '0) begin
            state_q <= ST_EMIT;
          end else begin
            scnt_q <= scnt_q - SW'(1);
          end
        end
        default: begin
          if (res_ready_i) begin
            ecnt_q <= ecnt_q + CW'(1);
            if (emit_last) state_q <= ST_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= item_i;
    end
  end

endmodule

### sv/multi_stream_dma_controller.sv
// Top level of the multi-stream DMA controller.
`timescale 1ns / 1ps
`include "multi_stream_dma_controller_defines.svh"
// Register file and transfer sequencer for up to eight DMA streams. Beats enter a
// two-entry queue and are executed one at a time by the sequencer. A register
// write, read or peripheral request is picked up, executed and then replied to.
// A service tick walks the streams from the highest down, one per cycle, then
// emits its transfer commands and the closing status beat. Every result beat
// carries the interrupt levels after the whole item; the last beat of each item
// is a status beat with last set.
module multi_stream_dma_controller #(
  parameter int unsigned STREAMS     = 8,
  parameter int unsigned QUEUE_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [5:0]  reg_index_i,
  input  logic [1:0]  byte_offset_i,
  input  logic [2:0]  access_bytes_i,
  input  logic [31:0] write_data_i,
  input  logic        request_dir_i,
  input  logic [31:0] request_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic [31:0] read_data_o,
  output logic [2:0]  xfer_stream_o,
  output logic [31:0] xfer_source_o,
  output logic [31:0] xfer_dest_o,
  output logic [2:0]  source_bytes_o,
  output logic [2:0]  dest_bytes_o,
  output logic [7:0]  irq_lines_o,
  output logic        last_o
);

  msdma_pkg::item_t        item;
  logic                    item_valid;
  logic                    pop;
  logic                    res_valid;
  logic                    res_ready;
  msdma_pkg::result_t      res;
  msdma_pkg::exec_status_t status;
  logic                    out_valid_q;
  msdma_pkg::result_t      out_q;

  msdma_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .opcode_i          (opcode_i),
    .reg_index_i       (reg_index_i),
    .byte_offset_i     (byte_offset_i),
    .access_bytes_i    (access_bytes_i),
    .write_data_i      (write_data_i),
    .request_dir_i     (request_dir_i),
    .request_address_i (request_address_i),
    .pop_i             (pop),
    .item_valid_o      (item_valid),
    .item_o            (item)
  );

  msdma_exec #(
    .STREAMS     (STREAMS),
    .QUEUE_SLOTS (QUEUE_SLOTS)
  ) u_exec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .pop_o        (pop),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .status_o     (status)
  );

  // Output register: refills whenever it is empty or being taken.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = out_q.kind;
  assign read_data_o    = out_q.read_data;
  assign xfer_stream_o  = out_q.cmd.stream;
  assign xfer_source_o  = out_q.cmd.source;
  assign xfer_dest_o    = out_q.cmd.dest;
  assign source_bytes_o = out_q.cmd.source_bytes;
  assign dest_bytes_o   = out_q.cmd.dest_bytes;
  assign irq_lines_o    = out_q.irq_lines;
  assign last_o         = out_q.last;

  // The closing beat of an item is always a status beat.
  `MSDMA_ASSERT_NEVER(a_last_is_reply, clk_i, rst_ni, out_valid_o && last_o && result_kind_o)
  // Every beat before the closing one is a transfer command.
  `MSDMA_ASSERT(a_inner_is_xfer, clk_i, rst_ni, out_valid_o && !last_o |-> result_kind_o)
  // The sequencer offers results only while it is in its emit phase.
  `MSDMA_ASSERT(a_res_when_emit, clk_i, rst_ni, res_valid |-> status.busy && status.emitting)

endmodule

### dv/multi_stream_dma_controller_test.sv
// Self-checking testbench for the multi-stream DMA controller.
`timescale 1ns / 1ps
module multi_stream_dma_controller_test;

  localparam int WatchdogLimit = 5000;

  typedef struct {
    logic [1:0]  opcode;
    logic [5:0]  reg_index;
    logic [1:0]  byte_offset;
    logic [2:0]  access_bytes;
    logic [31:0] write_data;
    logic        request_dir;
    logic [31:0] request_address;
  } dma_op_t;

  typedef struct {
    logic        kind;
    logic [31:0] read_data;
    logic [2:0]  stream;
    logic [31:0] source;
    logic [31:0] dest;
    logic [2:0]  source_bytes;
    logic [2:0]  dest_bytes;
    logic [7:0]  irq_lines;
    logic        last;
  } dma_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  opcode_i = '0;
  logic [5:0]  reg_index_i = '0;
  logic [1:0]  byte_offset_i = '0;
  logic [2:0]  access_bytes_i = '0;
  logic [31:0] write_data_i = '0;
  logic        request_dir_i = 1'b0;
  logic [31:0] request_address_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        result_kind_o;
  logic [31:0] read_data_o;
  logic [2:0]  xfer_stream_o;
  logic [31:0] xfer_source_o;
  logic [31:0] xfer_dest_o;
  logic [2:0]  source_bytes_o;
  logic [2:0]  dest_bytes_o;
  logic [7:0]  irq_lines_o;
  logic        last_o;

  multi_stream_dma_controller u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the controller state.
  logic [31:0] flags [2];
  logic [31:0] ctrl [8];
  logic [31:0] count [8];
  logic [31:0] periph [8];
  logic [31:0] mem0 [8];
  logic [31:0] mem1 [8];
  logic [31:0] fifo [8];
  logic [15:0] saved_count [8];
  logic [31:0] saved_mem [8];
  logic [31:0] saved_periph [8];
  logic [7:0]  pending [8];
  logic [31:0] parked_addr [2][8];
  logic [7:0]  parked_valid [2];

  dma_op_t   op_q [$];
  dma_beat_t beat_q [$];
  dma_op_t   cur_op;
  logic [31:0] addr_pool [12];
  int errors = 0;
  int cycles = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  function automatic logic [4:0] flag_shift(int s);
    return (s[1] ? 5'd16 : 5'd0) + (s[0] ? 5'd6 : 5'd0);
  endfunction

  function automatic logic [2:0] code_bytes(logic [1:0] c);
    return (c == 2'd0) ? 3'd1 : (c == 2'd1) ? 3'd2 : (c == 2'd2) ? 3'd4 : 3'd0;
  endfunction

  function automatic logic [7:0] irq_levels();
    logic [7:0]  lines;
    logic [31:0] sr;
    logic [31:0] en;
    lines = '0;
    for (int s = 0; s < 8; s++) begin
      sr = (flags[s > 3 ? 1 : 0] >> flag_shift(s)) & 32'(msdma_pkg::FlagGroup);
      en = ((ctrl[s] & 32'(msdma_pkg::EnableGroup)) << 1) | 32'(fifo[s][7]);
      if ((sr & en) != 0) lines[s] = 1'b1;
    end
    return lines;
  endfunction

  function automatic logic [31:0] reg_read(int idx);
    int s;
    int w;
    if (idx < 2) return flags[idx];
    if (idx < int'(msdma_pkg::FirstStreamWord) || idx >= int'(msdma_pkg::MapWords)) begin
      return 32'd0;
    end
    s = (idx - int'(msdma_pkg::FirstStreamWord)) / int'(msdma_pkg::WordsPerStream);
    w = (idx - int'(msdma_pkg::FirstStreamWord)) % int'(msdma_pkg::WordsPerStream);
    case (3'(w))
      msdma_pkg::WordCtrl:   return ctrl[s];
      msdma_pkg::WordCount:  return count[s];
      msdma_pkg::WordPeriph: return periph[s];
      msdma_pkg::WordMem0:   return mem0[s];
      msdma_pkg::WordMem1:   return mem1[s];
      default:               return fifo[s];
    endcase
  endfunction

  task automatic bump_pending(int s);
    if (pending[s] != 8'hFF) pending[s]++;
  endtask

  task automatic reg_write(int idx, logic [31:0] v);
    int s;
    int w;
    logic [1:0] dir;
    if (idx < 2 || idx >= int'(msdma_pkg::MapWords)) return;
    if (idx < int'(msdma_pkg::FirstStreamWord)) begin
      flags[idx - 2] &= ~v;
      return;
    end
    s = (idx - int'(msdma_pkg::FirstStreamWord)) / int'(msdma_pkg::WordsPerStream);
    w = (idx - int'(msdma_pkg::FirstStreamWord)) % int'(msdma_pkg::WordsPerStream);
    case (3'(w))
      msdma_pkg::WordCtrl: begin
        // A rising enable takes one parked request; a falling one restores addresses.
        if (!ctrl[s][0] && v[0]) begin
          dir = v[7:6];
          if (dir < 2) begin
            for (int q = 0; q < 8; q++) begin
              if (parked_valid[dir][q] && parked_addr[dir][q] == periph[s]) begin
                parked_valid[dir][q] = 1'b0;
                parked_addr[dir][q] = '0;
                bump_pending(s);
                break;
              end
            end
          end
        end else if (ctrl[s][0] && !v[0]) begin
          mem0[s] = saved_mem[s];
          periph[s] = saved_periph[s];
        end
        ctrl[s] = v;
      end
      msdma_pkg::WordCount: begin
        saved_count[s] = v[15:0];
        count[s] = v;
      end
      msdma_pkg::WordPeriph: begin
        saved_periph[s] = v;
        periph[s] = v;
      end
      msdma_pkg::WordMem0: begin
        saved_mem[s] = v;
        mem0[s] = v;
      end
      msdma_pkg::WordMem1: mem1[s] = v;
      default:             fifo[s] = v;
    endcase
  endtask

  task automatic peripheral_request(logic dir, logic [31:0] addr);
    bit hit;
    int empty;
    hit = 1'b0;
    empty = -1;
    for (int s = 0; s < 8; s++) begin
      if (periph[s] != addr || ctrl[s][7:6] != {1'b0, dir}) continue;
      if (!ctrl[s][0] || count[s] == 0) continue;
      bump_pending(s);
      hit = 1'b1;
    end
    if (hit) return;
    // No stream ready: park the request unless it is already parked.
    for (int q = 0; q < 8; q++) begin
      if (parked_valid[dir][q]) begin
        if (parked_addr[dir][q] == addr) return;
      end else if (empty < 0) begin
        empty = q;
      end
    end
    if (empty >= 0) begin
      parked_addr[dir][empty] = addr;
      parked_valid[dir][empty] = 1'b1;
    end
  endtask

  task automatic run_stream(int s, ref dma_beat_t beats [$]);
    logic [31:0] cr;
    logic [2:0]  psz;
    logic [2:0]  msz;
    logic [31:0] pinc;
    logic [31:0] minc;
    dma_beat_t   b;
    cr = ctrl[s];
    psz = code_bytes(cr[12:11]);
    msz = code_bytes(cr[14:13]);
    pinc = cr[9] ? (cr[15] ? 32'd4 : 32'(psz)) : 32'd0;
    minc = cr[10] ? 32'(msz) : 32'd0;
    if (!cr[0] || cr[7]) return;
    b = '{msdma_pkg::KindXfer, '0, 3'(s), '0, '0, '0, '0, '0, 1'b0};
    if (!cr[6]) begin
      b.source = periph[s]; b.dest = mem0[s]; b.source_bytes = psz; b.dest_bytes = msz;
    end else begin
      b.source = mem0[s]; b.dest = periph[s]; b.source_bytes = msz; b.dest_bytes = psz;
    end
    beats.push_back(b);
    count[s]--;
    periph[s] += pinc;
    mem0[s] += minc;
    // Complete wins over half; circular mode reloads, otherwise the stream stops.
    if (count[s] == 0) begin
      flags[s > 3 ? 1 : 0] |= 32'(msdma_pkg::FlagDone) << flag_shift(s);
      if (cr[8]) begin
        count[s] = 32'(saved_count[s]);
        periph[s] -= 32'(saved_count[s]) * pinc;
        mem0[s] -= 32'(saved_count[s]) * minc;
      end else begin
        ctrl[s] = cr & ~32'd1;
      end
    end else if (count[s] == 32'(saved_count[s] >> 1)) begin
      flags[s > 3 ? 1 : 0] |= 32'(msdma_pkg::FlagHalf) << flag_shift(s);
    end
  endtask

  // Work out the result beats of one accepted operation.
  task automatic predict_beats(dma_op_t op);
    dma_beat_t   beats [$];
    dma_beat_t   status;
    logic [31:0] mask;
    logic [31:0] m;
    logic [31:0] base;
    logic [4:0]  sh;
    bit          lane_ok;
    logic [7:0]  lines;
    status = '{msdma_pkg::KindReply, '0, '0, '0, '0, '0, '0, '0, 1'b0};
    lane_ok = 1'b1;
    mask = '1;
    sh = '0;
    if (op.access_bytes == 3'd2) begin
      mask = 32'hFFFF;
      sh = 5'(op.byte_offset) * 5'd8;
    end else if (op.access_bytes != 3'd4) begin
      lane_ok = 1'b0;
    end
    case (op.opcode)
      msdma_pkg::OpWrite: begin
        if (lane_ok) begin
          base = (op.reg_index == 6'd2 || op.reg_index == 6'd3) ? 32'd0 :
                 reg_read(int'(op.reg_index));
          m = mask << sh;
          reg_write(int'(op.reg_index), (base & ~m) | ((op.write_data << sh) & m));
        end
        beats.push_back(status);
      end
      msdma_pkg::OpRead: begin
        if (lane_ok) status.read_data = (reg_read(int'(op.reg_index)) >> sh) & mask;
        beats.push_back(status);
      end
      msdma_pkg::OpRequest: begin
        peripheral_request(op.request_dir, op.request_address);
        beats.push_back(status);
      end
      default: begin
        for (int s = 7; s >= 0; s--) begin
          if (pending[s] != 0) begin
            run_stream(s, beats);
            pending[s]--;
          end
        end
        beats.push_back(status);
      end
    endcase
    lines = irq_levels();
    beats[beats.size() - 1].last = 1'b1;
    foreach (beats[k]) begin
      beats[k].irq_lines = lines;
      beat_q.push_back(beats[k]);
    end
  endtask

  task automatic add_op(logic [1:0] opc, int idx, int off, int sz, logic [31:0] data,
                        logic dir, logic [31:0] addr);
    dma_op_t op;
    op = '{opc, 6'(idx), 2'(off), 3'(sz), data, dir, addr};
    op_q.push_back(op);
  endtask

  function automatic int stream_reg(int s, logic [2:0] w);
    return int'(msdma_pkg::FirstStreamWord) + s * int'(msdma_pkg::WordsPerStream) + int'(w);
  endfunction

  // One random operation, mostly stream setup, requests and ticks.
  task automatic add_random_op();
    int          pick;
    int          s;
    logic [31:0] v;
    logic [31:0] addr;
    pick = $urandom_range(0, 99);
    s = $urandom_range(0, 7);
    addr = addr_pool[$urandom_range(0, 11)];
    if (pick < 12) begin
      v = $urandom;
      v[7:6] = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
      add_op(msdma_pkg::OpWrite, stream_reg(s, msdma_pkg::WordCtrl), 0, 4, v, 1'b0, '0);
    end else if (pick < 20) begin
      v = ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(0, 8));
      add_op(msdma_pkg::OpWrite, stream_reg(s, msdma_pkg::WordCount), 0, 4, v, 1'b0, '0);
    end else if (pick < 26) begin
      add_op(msdma_pkg::OpWrite, stream_reg(s, msdma_pkg::WordPeriph), 0, 4, addr, 1'b0, '0);
    end else if (pick < 31) begin
      add_op(msdma_pkg::OpWrite, stream_reg(s, 3'($urandom_range(3, 5))), 0, 4, $urandom,
             1'b0, '0);
    end else if (pick < 35) begin
      add_op(msdma_pkg::OpWrite, $urandom_range(2, 3), $urandom_range(0, 3),
             ($urandom_range(0, 1) != 0) ? 4 : 2, $urandom, 1'b0, '0);
    end else if (pick < 45) begin
      add_op(msdma_pkg::OpRead, $urandom_range(0, 51), $urandom_range(0, 3),
             ($urandom_range(0, 3) == 0) ? 2 : 4, $urandom, 1'($urandom), $urandom);
    end else if (pick < 68) begin
      add_op(msdma_pkg::OpRequest, $urandom_range(0, 51), $urandom_range(0, 3),
             $urandom_range(0, 7), $urandom, 1'($urandom), addr);
    end else if (pick < 90) begin
      add_op(msdma_pkg::OpTick, $urandom_range(0, 51), $urandom_range(0, 3),
             $urandom_range(0, 7), $urandom, 1'($urandom), $urandom);
    end else begin
      add_op(2'($urandom_range(0, 3)), $urandom_range(0, 51), $urandom_range(0, 3),
             $urandom_range(0, 7), $urandom, 1'($urandom), $urandom);
    end
  endtask

  function automatic bit idle_now(bit quiet);
    return !quiet && ($urandom_range(0, 99) < 25);
  endfunction

  // Driver: offers pending operations and records each accepted beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (in_valid_i && !in_stall_o) predict_beats(cur_op);
      if (!in_valid_i || !in_stall_o) begin
        if (op_q.size() != 0 && !idle_now(cycles > 800 && cycles < 1100)) begin
          cur_op = op_q.pop_front();
          in_valid_i <= 1'b1;
          opcode_i <= cur_op.opcode;
          reg_index_i <= cur_op.reg_index;
          byte_offset_i <= cur_op.byte_offset;
          access_bytes_i <= cur_op.access_bytes;
          write_data_i <= cur_op.write_data;
          request_dir_i <= cur_op.request_dir;
          request_address_i <= cur_op.request_address;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall, with one long hold-off so that the input backs up.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (!hold_done && cycles >= 300) begin
        hold_done <= 1'b1;
        hold_left <= 200;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= idle_now(cycles > 800 && cycles < 1100);
      end
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Monitor: compares each accepted result beat with the oldest expectation.
  always @(posedge clk_i) begin
    dma_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (beat_q.size() == 0) begin
        report_mismatch("unexpected beat", {31'd0, result_kind_o}, '0);
      end else begin
        want = beat_q.pop_front();
        check_field("result_kind", 32'(result_kind_o), 32'(want.kind));
        check_field("read_data", read_data_o, want.read_data);
        check_field("xfer_stream", 32'(xfer_stream_o), 32'(want.stream));
        check_field("xfer_source", xfer_source_o, want.source);
        check_field("xfer_dest", xfer_dest_o, want.dest);
        check_field("source_bytes", 32'(source_bytes_o), 32'(want.source_bytes));
        check_field("dest_bytes", 32'(dest_bytes_o), 32'(want.dest_bytes));
        check_field("irq_lines", 32'(irq_lines_o), 32'(want.irq_lines));
        check_field("last", 32'(last_o), 32'(want.last));
      end
    end
  end

  // Watchdog on cycles in which no beat moves on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog expired");
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    foreach (flags[i]) flags[i] = '0;
    for (int s = 0; s < 8; s++) begin
      ctrl[s] = '0; count[s] = '0; periph[s] = '0; mem0[s] = '0; mem1[s] = '0;
      fifo[s] = '0; saved_count[s] = '0; saved_mem[s] = '0; saved_periph[s] = '0;
      pending[s] = '0;
      parked_addr[0][s] = '0;
      parked_addr[1][s] = '0;
    end
    parked_valid[0] = '0;
    parked_valid[1] = '0;
    addr_pool[0] = 32'h0;
    addr_pool[1] = 32'hFFFF_FFFF;
    addr_pool[2] = 32'h4000_0000;
    addr_pool[3] = 32'h4001_3004;
    foreach (addr_pool[i]) if (i > 3) addr_pool[i] = $urandom;

    // Directed: one stream run to half, another to complete, parking, lanes and odd sizes.
    add_op(msdma_pkg::OpRead, 0, 0, 4, '0, 1'b0, '0);
    add_op(msdma_pkg::OpWrite, stream_reg(0, msdma_pkg::WordCount), 0, 4, 32'd4, 1'b0, '0);
    add_op(msdma_pkg::OpWrite, stream_reg(0, msdma_pkg::WordPeriph), 0, 4, 32'hFFFF_FFFF,
           1'b0, '0);
    add_op(msdma_pkg::OpWrite, stream_reg(0, msdma_pkg::WordMem0), 0, 4, 32'h2000_0000,
           1'b0, '0);
    add_op(msdma_pkg::OpWrite, stream_reg(0, msdma_pkg::WordCtrl), 0, 4, 32'h0000_4E1F,
           1'b0, '0);
    add_op(msdma_pkg::OpRequest, 0, 0, 4, '0, 1'b0, 32'hFFFF_FFFF);
    add_op(msdma_pkg::OpRequest, 0, 0, 4, '0, 1'b0, 32'hFFFF_FFFF);
    add_op(msdma_pkg::OpTick, 0, 0, 4, '0, 1'b0, '0);
    add_op(msdma_pkg::OpTick, 0, 0, 4, '0, 1'b0, '0);
    add_op(msdma_pkg::OpRequest, 0, 0, 4, '0, 1'b1, 32'h0);
    add_op(msdma_pkg::OpRequest, 0, 0, 4, '0, 1'b1, 32'h0);
    add_op(msdma_pkg::OpWrite, stream_reg(1, msdma_pkg::WordCount), 0, 4, 32'd1, 1'b0, '0);
    add_op(msdma_pkg::OpWrite, stream_reg(1, msdma_pkg::WordCtrl), 0, 4, 32'h0000_835F,
           1'b0, '0);
    add_op(msdma_pkg::OpTick, 0, 0, 4, '0, 1'b0, '0);
    add_op(msdma_pkg::OpWrite, stream_reg(2, msdma_pkg::WordMem1), 3, 2, 32'hFFFF_FFFF,
           1'b0, '0);
    add_op(msdma_pkg::OpRead, stream_reg(2, msdma_pkg::WordMem1), 1, 2, '0, 1'b0, '0);
    add_op(msdma_pkg::OpWrite, 51, 0, 3, 32'hFFFF_FFFF, 1'b0, '0);
    add_op(msdma_pkg::OpRead, 51, 0, 0, '0, 1'b0, '0);
    add_op(msdma_pkg::OpWrite, 1, 0, 4, 32'hFFFF_FFFF, 1'b0, '0);
    add_op(msdma_pkg::OpWrite, 2, 2, 2, 32'hFFFF_FFFF, 1'b0, '0);
    add_op(msdma_pkg::OpWrite, stream_reg(4, msdma_pkg::WordCount), 0, 4, 32'd2, 1'b0, '0);
    add_op(msdma_pkg::OpWrite, stream_reg(4, msdma_pkg::WordCtrl), 0, 4, 32'h0000_001F,
           1'b0, '0);
    add_op(msdma_pkg::OpRequest, 0, 0, 4, '0, 1'b0, 32'h0);
    add_op(msdma_pkg::OpWrite, stream_reg(4, msdma_pkg::WordCount), 0, 4, 32'd0, 1'b0, '0);
    add_op(msdma_pkg::OpTick, 0, 0, 4, '0, 1'b0, '0);
    add_op(msdma_pkg::OpWrite, stream_reg(0, msdma_pkg::WordCtrl), 0, 4, 32'h0, 1'b0, '0);
    repeat (104) add_random_op();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (op_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (beat_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
